// ===== rtl/gzip_member_framing_checker_macros.svh =====
// Assertion macros for the gzip member framing checker.
// Used by rtl/gzip_member_framing_checker.sv; assumes clk and rst_n in scope.
`ifndef GZIP_MEMBER_FRAMING_CHECKER_MACROS_SVH
`define GZIP_MEMBER_FRAMING_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
`define GMFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gmfc assertion failed");
`define GMFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gmfc assertion failed");
`else
`define GMFC_ASSERT_SAME(label, ante, cons)
`define GMFC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/gmfc_pkg.sv =====
// Package for the gzip member framing checker: phase type, status codes,
// register indexes and framing constants. No dependencies.
`timescale 1ns / 1ps

package gmfc_pkg;

    typedef enum logic [7:0] {
        PH_FIXED   = 8'b0000_0001,
        PH_XLEN    = 8'b0000_0010,
        PH_XDATA   = 8'b0000_0100,
        PH_NAME    = 8'b0000_1000,
        PH_COMMENT = 8'b0001_0000,
        PH_HCRC    = 8'b0010_0000,
        PH_BODY    = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } phase_t;

    typedef enum logic [1:0] {
        FROM_FIXED   = 2'd0,
        FROM_XDATA   = 2'd1,
        FROM_NAME    = 2'd2,
        FROM_COMMENT = 2'd3
    } section_from_t;

    localparam logic [3:0] ST_HEADER   = 4'd0;
    localparam logic [3:0] ST_HEND     = 4'd1;
    localparam logic [3:0] ST_PAYLOAD  = 4'd2;
    localparam logic [3:0] ST_TRAILER  = 4'd3;
    localparam logic [3:0] ST_DONE     = 4'd4;
    localparam logic [3:0] ST_TOOLARGE = 4'd5;
    localparam logic [3:0] ST_MAGIC    = 4'd6;
    localparam logic [3:0] ST_METHOD   = 4'd7;
    localparam logic [3:0] ST_FLAGS    = 4'd8;
    localparam logic [3:0] ST_TRUNC    = 4'd9;
    localparam logic [3:0] ST_NONE     = 4'd0;

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILE_LENGTH     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_OUTPUT_SIZE = 2'd1;

    localparam logic [31:0] FILE_LENGTH_RESET     = 32'd0;
    localparam logic [31:0] MAX_OUTPUT_SIZE_RESET = 32'(8 * 1024 * 1024);

    localparam logic [7:0]  MAGIC_0        = 8'h1F;
    localparam logic [7:0]  MAGIC_1        = 8'h8B;
    localparam logic [7:0]  METHOD_DEFLATE = 8'd8;
    localparam logic [7:0]  FLAG_RESERVED  = 8'hE0;
    localparam logic [31:0] MIN_FILE_LEN   = 32'd18;
    localparam logic [31:0] MIN_EXTRA_LEN  = 32'd20;
    localparam logic [31:0] TRAILER_LEN    = 32'd8;
    localparam logic [31:0] FIXED_LAST     = 32'd9;
    localparam logic [31:0] XLEN_FIRST     = 32'd10;
    localparam logic [15:0] HCRC_LEN       = 16'd2;

    localparam int FLG_HCRC    = 1;
    localparam int FLG_EXTRA   = 2;
    localparam int FLG_NAME    = 3;
    localparam int FLG_COMMENT = 4;

    function automatic phase_t next_section(input section_from_t from, input logic [4:0] flags);
        phase_t ph;
        ph = PH_BODY;
        if (from == FROM_FIXED && flags[FLG_EXTRA])
        begin
            ph = PH_XLEN;
        end
        else if ((from == FROM_FIXED || from == FROM_XDATA) && flags[FLG_NAME])
        begin
            ph = PH_NAME;
        end
        else if (from != FROM_COMMENT && flags[FLG_COMMENT])
        begin
            ph = PH_COMMENT;
        end
        else if (flags[FLG_HCRC])
        begin
            ph = PH_HCRC;
        end
        return ph;
    endfunction

endpackage

// ===== rtl/gzip_member_framing_checker.sv =====
// gzip member framing checker: one byte per beat, header/trailer tagging.
// Depends on gmfc_pkg and gzip_member_framing_checker_macros.svh.
`timescale 1ns / 1ps

// Accepts one file byte per clock unless stalled and returns one tagged result
// per byte from the result register. The whole per-byte update (phase, offset,
// counters, trailer gathering) is combinational between the state registers
// and the result register, so the rate is one byte per cycle. The result and
// one-entry skid registers decouple the two sides: in_stall rises only once
// the skid entry is in use. Errors hold until a byte with start_of_file.
// Write file_length and max_output_size only while idle.
module gzip_member_framing_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [gmfc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [7:0]                      data_byte,
    input  logic                            start_of_file,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [3:0]                      status,
    output logic [7:0]                      byte_out,
    output logic [31:0]                     header_length,
    output logic [31:0]                     stored_crc,
    output logic [31:0]                     stored_size
);

    `include "gzip_member_framing_checker_macros.svh"

    typedef struct packed {
        logic [3:0]  status;
        logic [7:0]  byte_out;
        logic [31:0] header_length;
        logic [31:0] stored_crc;
        logic [31:0] stored_size;
    } result_t;

    logic [31:0]      file_length_reg;
    logic [31:0]      max_output_size_reg;
    gmfc_pkg::phase_t phase_reg;
    gmfc_pkg::phase_t phase_next;
    logic [31:0]      offset_reg;
    logic [31:0]      offset_next;
    logic [4:0]       flags_reg;
    logic [4:0]       flags_next;
    logic [15:0]      extra_reg;
    logic [15:0]      extra_next;
    logic [31:0]      header_count_reg;
    logic [31:0]      header_count_next;
    logic [31:0]      crc_reg;
    logic [31:0]      crc_next;
    logic [31:0]      size_reg;
    logic [31:0]      size_next;
    logic [3:0]       error_code_reg;
    logic [3:0]       error_code_next;
    result_t          result_next;
    result_t          out_reg;
    result_t          skid_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;
    logic             in_fire;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;

    always_comb
    begin
        gmfc_pkg::phase_t cur_phase;
        gmfc_pkg::phase_t nxt;
        logic [31:0] off;
        logic [4:0]  flags;
        logic [15:0] ext;
        logic [31:0] hcount;
        logic [31:0] crc;
        logic [31:0] size;
        logic [3:0]  ecode;
        logic [31:0] tstart;
        logic [31:0] idx;
        logic [32:0] off_inc;
        logic [3:0]  err;
        logic [3:0]  st;

        cur_phase = start_of_file ? gmfc_pkg::PH_FIXED : phase_reg;
        off       = start_of_file ? '0 : offset_reg;
        flags     = start_of_file ? '0 : flags_reg;
        ext       = start_of_file ? '0 : extra_reg;
        hcount    = start_of_file ? '0 : header_count_reg;
        crc       = start_of_file ? '0 : crc_reg;
        size      = start_of_file ? '0 : size_reg;
        ecode     = start_of_file ? gmfc_pkg::ST_NONE : error_code_reg;
        tstart    = (file_length_reg >= gmfc_pkg::TRAILER_LEN)
                    ? file_length_reg - gmfc_pkg::TRAILER_LEN : '0;
        idx       = off - tstart;
        off_inc   = {1'b0, off} + 33'd1;
        nxt       = cur_phase;
        err       = gmfc_pkg::ST_NONE;
        st        = gmfc_pkg::ST_HEADER;

        if (cur_phase == gmfc_pkg::PH_ERROR)
        begin
            st = ecode;
        end
        else if (cur_phase == gmfc_pkg::PH_BODY)
        begin
            if (off < tstart)
            begin
                st = gmfc_pkg::ST_PAYLOAD;
            end
            else
            begin
                if (off < file_length_reg)
                begin
                    if (idx < 32'd4)
                    begin
                        crc = crc | ({24'd0, data_byte} << {idx[1:0], 3'd0});
                    end
                    else if (idx < 32'd8)
                    begin
                        size = size | ({24'd0, data_byte} << {idx[1:0], 3'd0});
                    end
                end
                if (off_inc < {1'b0, file_length_reg})
                begin
                    st = gmfc_pkg::ST_TRAILER;
                end
                else
                begin
                    st = (size > max_output_size_reg) ? gmfc_pkg::ST_TOOLARGE
                                                      : gmfc_pkg::ST_DONE;
                end
            end
        end
        else
        begin
            case (cur_phase)
                gmfc_pkg::PH_FIXED:
                begin
                    if (off == 32'd0)
                    begin
                        if (file_length_reg < gmfc_pkg::MIN_FILE_LEN)
                        begin
                            err = gmfc_pkg::ST_TRUNC;
                        end
                        else if (data_byte != gmfc_pkg::MAGIC_0)
                        begin
                            err = gmfc_pkg::ST_MAGIC;
                        end
                    end
                    else if (off == 32'd1)
                    begin
                        if (data_byte != gmfc_pkg::MAGIC_1)
                        begin
                            err = gmfc_pkg::ST_MAGIC;
                        end
                    end
                    else if (off == 32'd2)
                    begin
                        if (data_byte != gmfc_pkg::METHOD_DEFLATE)
                        begin
                            err = gmfc_pkg::ST_METHOD;
                        end
                    end
                    else if (off == 32'd3)
                    begin
                        if ((data_byte & gmfc_pkg::FLAG_RESERVED) != 8'd0)
                        begin
                            err = gmfc_pkg::ST_FLAGS;
                        end
                        else
                        begin
                            flags = data_byte[4:0];
                            if (flags[gmfc_pkg::FLG_EXTRA]
                                && file_length_reg < gmfc_pkg::MIN_EXTRA_LEN)
                            begin
                                err = gmfc_pkg::ST_TRUNC;
                            end
                        end
                    end
                    else if (off >= gmfc_pkg::FIXED_LAST)
                    begin
                        nxt = gmfc_pkg::next_section(gmfc_pkg::FROM_FIXED, flags);
                    end
                end
                gmfc_pkg::PH_XLEN:
                begin
                    if (off == gmfc_pkg::XLEN_FIRST)
                    begin
                        ext = {8'd0, data_byte};
                    end
                    else
                    begin
                        ext = {ext[15:8] | data_byte, ext[7:0]};
                        if ({1'b0, file_length_reg}
                            < {1'b0, gmfc_pkg::MIN_EXTRA_LEN} + {17'd0, ext})
                        begin
                            err = gmfc_pkg::ST_TRUNC;
                        end
                        else if (ext != 16'd0)
                        begin
                            nxt = gmfc_pkg::PH_XDATA;
                        end
                        else
                        begin
                            nxt = gmfc_pkg::next_section(gmfc_pkg::FROM_XDATA, flags);
                        end
                    end
                end
                gmfc_pkg::PH_XDATA:
                begin
                    ext = ext - 16'd1;
                    if (ext == 16'd0)
                    begin
                        nxt = gmfc_pkg::next_section(gmfc_pkg::FROM_XDATA, flags);
                    end
                end
                gmfc_pkg::PH_NAME:
                begin
                    if (data_byte == 8'd0)
                    begin
                        nxt = gmfc_pkg::next_section(gmfc_pkg::FROM_NAME, flags);
                    end
                end
                gmfc_pkg::PH_COMMENT:
                begin
                    if (data_byte == 8'd0)
                    begin
                        nxt = gmfc_pkg::next_section(gmfc_pkg::FROM_COMMENT, flags);
                    end
                end
                default:
                begin
                    ext = ext - 16'd1;
                    if (ext == 16'd0)
                    begin
                        nxt = gmfc_pkg::PH_BODY;
                    end
                end
            endcase

            // load header CRC byte count on entry
            if (nxt == gmfc_pkg::PH_HCRC && cur_phase != gmfc_pkg::PH_HCRC)
            begin
                ext = gmfc_pkg::HCRC_LEN;
            end
            if (err == gmfc_pkg::ST_NONE && off >= tstart)
            begin
                err = gmfc_pkg::ST_TRUNC;
            end
            hcount = hcount + 32'd1;
            if (err != gmfc_pkg::ST_NONE)
            begin
                nxt   = gmfc_pkg::PH_ERROR;
                ecode = err;
                st    = err;
            end
            else
            begin
                st = (nxt == gmfc_pkg::PH_BODY) ? gmfc_pkg::ST_HEND : gmfc_pkg::ST_HEADER;
            end
        end

        phase_next      = nxt;
        offset_next     = (off == '1) ? off : off_inc[31:0];
        flags_next      = flags;
        extra_next      = ext;
        header_count_next = hcount;
        crc_next        = crc;
        size_next       = size;
        error_code_next = ecode;

        result_next.status        = st;
        result_next.byte_out      = data_byte;
        result_next.header_length = hcount;
        result_next.stored_crc    = crc;
        result_next.stored_size   = size;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            file_length_reg     <= gmfc_pkg::FILE_LENGTH_RESET;
            max_output_size_reg <= gmfc_pkg::MAX_OUTPUT_SIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == gmfc_pkg::CFG_FILE_LENGTH)
            begin
                file_length_reg <= cfg_data;
            end
            else if (cfg_index == gmfc_pkg::CFG_MAX_OUTPUT_SIZE)
            begin
                max_output_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= gmfc_pkg::PH_FIXED;
            offset_reg       <= '0;
            flags_reg        <= '0;
            extra_reg        <= '0;
            header_count_reg <= '0;
            crc_reg          <= '0;
            size_reg         <= '0;
            error_code_reg   <= gmfc_pkg::ST_NONE;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            offset_reg       <= offset_next;
            flags_reg        <= flags_next;
            extra_reg        <= extra_next;
            header_count_reg <= header_count_next;
            crc_reg          <= crc_next;
            size_reg         <= size_next;
            error_code_reg   <= error_code_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= result_next;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_reg.status;
    assign byte_out      = out_reg.byte_out;
    assign header_length = out_reg.header_length;
    assign stored_crc    = out_reg.stored_crc;
    assign stored_size   = out_reg.stored_size;

    `GMFC_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `GMFC_ASSERT_NEXT(a_sof_restarts_offset, in_fire && start_of_file, offset_reg == 32'd1)
    `GMFC_ASSERT_SAME(a_error_code_valid, phase_reg == gmfc_pkg::PH_ERROR, (error_code_reg == gmfc_pkg::ST_MAGIC || error_code_reg == gmfc_pkg::ST_METHOD || error_code_reg == gmfc_pkg::ST_FLAGS || error_code_reg == gmfc_pkg::ST_TRUNC))
    `GMFC_ASSERT_NEXT(a_body_holds_header_count, in_fire && !start_of_file && phase_reg == gmfc_pkg::PH_BODY, $stable(header_count_reg))

endmodule
